/* src/rip_pkg.sv */
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the range image point projector
// Register indexes, CORDIC angle table, phase table sizes and pipeline side
// data carried next to the CORDIC cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

   localparam int COL_W       = 10;
   localparam int DIM_W       = 11;
   localparam int FOV_W       = 17;
   localparam int SCALE_W     = 24;
   localparam int RANGE_W     = 16;
   localparam int STRENGTH_W  = 8;
   localparam int POINT_W     = 33;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int PHASE_W     = 32;
   localparam int DIST_W      = 32;
   localparam int CORDIC_W    = 34;
   localparam int ANGLE_W     = 33;
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = 34'sd652032874;

   // Twice one turn in FOV units: den = span * DEN_STEP
   localparam int FOV_TURN    = 92160;
   localparam int DEN_STEP    = 2 * FOV_TURN;
   localparam int DEN_W       = 29;
   localparam int DIVIDEND_W  = FOV_W + PHASE_W;

   // Largest |2*index - span| for a 10-bit index and 11-bit dimension
   localparam int DIFF_MAX    = 2046;
   localparam int TABLE_DEPTH = DIFF_MAX + 1;
   localparam int DIFF_W      = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_FOV_HORIZONTAL = 3'd2,
      CSR_FOV_VERTICAL   = 3'd3,
      CSR_RANGE_SCALE    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PT_SETUP,
      PT_DIVIDE,
      PT_SWEEP,
      PT_IDLE
   } table_state_type;

   typedef logic signed [ANGLE_W-1:0] angle_array_type [CORDIC_STEPS];

   localparam angle_array_type ATAN_TURNS = '{
      33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4, 33'sh0028B0D43,
      33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55, 33'sh00028BE53, 33'sh000145F2F,
      33'sh0000A2F98, 33'sh0000517CC, 33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA,
      33'sh00000517D, 33'sh0000028BE, 33'sh00000145F, 33'sh000000A30, 33'sh000000518,
      33'sh00000028C, 33'sh000000146, 33'sh0000000A3, 33'sh000000051, 33'sh000000029,
      33'sh000000014, 33'sh00000000A, 33'sh000000005, 33'sh000000003, 33'sh000000001
   };

   typedef struct packed {
      logic                  valid;
      logic [DIST_W-1:0]     distance;
      logic [STRENGTH_W-1:0] intensity;
      logic [1:0]            quad_h;
      logic [1:0]            quad_v;
   } side_type;

endpackage

`default_nettype wire

/* src/rip_if.sv */
// ----------------------------------------------------------------------------
// rip_if: request and response channels of the range image point projector
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rip_req_if;
   logic                            valid;
   logic                            ready;
   logic [rip_pkg::COL_W-1:0]       column;
   logic [rip_pkg::COL_W-1:0]       row;
   logic [rip_pkg::RANGE_W-1:0]     range_value;
   logic [rip_pkg::STRENGTH_W-1:0]  strength_value;
   logic                            strength_valid;

   modport source (output valid, column, row, range_value, strength_value,
                   strength_valid, input ready);
   modport sink   (input valid, column, row, range_value, strength_value,
                   strength_valid, output ready);
endinterface

interface rip_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rip_pkg::POINT_W-1:0]     point_x;
   logic signed [rip_pkg::POINT_W-1:0]     point_y;
   logic signed [rip_pkg::POINT_W-1:0]     point_z;
   logic [rip_pkg::STRENGTH_W-1:0]         intensity;

   modport source (output valid, point_x, point_y, point_z, intensity, input ready);
   modport sink   (input valid, point_x, point_y, point_z, intensity, output ready);
endinterface

`default_nettype wire

/* src/range_image_point_projector_unit.sv */
// ----------------------------------------------------------------------------
// range_image_point_projector_unit: range image pixel to Cartesian point
// Distance from range count and scale, yaw and pitch phases from per-axis
// tables, sine/cosine from two rows of CORDIC cells, then two Q2.30 products.
//
//   channel | direction | contents
//   --------+-----------+-------------------------------------------------
//   req     | in        | column, row, range_value, strength_value/valid
//   rsp     | out       | point_x, point_y, point_z (Q16.16), intensity
//   csr     | in        | write enable, register index, write data
//
// One request per cycle unless rsp stalls or a table rebuilds; a stalled rsp
// freezes the whole pipeline of table read, phase, 30 CORDIC cells, quadrant
// map, two multiply stages and saturation. Zero range is dropped. After reset,
// and for an axis after a write to its dimension or field of view, the phase
// tables rebuild (a setup step, 49 divide steps, 2047 entries), req ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module range_image_point_projector_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rip_req_if.sink                                  req_chan,
   rip_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [rip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rip_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NS = rip_pkg::CORDIC_STEPS;
   localparam int PW = 36;
   localparam int QW = 38;

   // ---------------- configuration ----------------
   logic [rip_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [rip_pkg::FOV_W-1:0]   fov_h_ff, fov_v_ff;
   logic [rip_pkg::SCALE_W-1:0] scale_ff;
   logic                        start_h, start_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rip_pkg::DIM_W'(256);
         height_ff <= rip_pkg::DIM_W'(256);
         fov_h_ff  <= rip_pkg::FOV_W'(23040);
         fov_v_ff  <= rip_pkg::FOV_W'(5120);
         scale_ff  <= rip_pkg::SCALE_W'(16777);
      end else if (csr_we) begin
         unique case (csr_index)
            rip_pkg::CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[rip_pkg::DIM_W-1:0];
            rip_pkg::CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[rip_pkg::DIM_W-1:0];
            rip_pkg::CSR_FOV_HORIZONTAL: fov_h_ff  <= csr_wdata[rip_pkg::FOV_W-1:0];
            rip_pkg::CSR_FOV_VERTICAL:   fov_v_ff  <= csr_wdata[rip_pkg::FOV_W-1:0];
            rip_pkg::CSR_RANGE_SCALE:    scale_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign start_h = csr_we && (csr_index == rip_pkg::CSR_IMAGE_WIDTH ||
                               csr_index == rip_pkg::CSR_FOV_HORIZONTAL);
   assign start_v = csr_we && (csr_index == rip_pkg::CSR_IMAGE_HEIGHT ||
                               csr_index == rip_pkg::CSR_FOV_VERTICAL);

   // ---------------- handshake ----------------
   logic out_valid_ff;
   logic adv, busy_h, busy_v, accept;

   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !busy_h && !busy_v;
   assign accept         = req_chan.valid && req_chan.ready;

   // ---------------- stage A: index distance, table read, distance ----------------
   logic [rip_pkg::DIM_W-1:0]  span_h, span_v, twice_h, twice_v;
   logic                       neg_h, neg_v;
   logic [rip_pkg::DIFF_W-1:0] diff_h, diff_v;
   logic [rip_pkg::PHASE_W-1:0] q_h, q_v;
   logic [rip_pkg::RANGE_W+rip_pkg::SCALE_W-1:0] dist_prod;

   always_comb begin
      span_h  = width_ff - rip_pkg::DIM_W'(1);
      span_v  = height_ff - rip_pkg::DIM_W'(1);
      twice_h = {req_chan.column, 1'b0};
      twice_v = {req_chan.row, 1'b0};
      neg_h   = twice_h < span_h;
      neg_v   = twice_v < span_v;
      diff_h  = neg_h ? span_h - twice_h : twice_h - span_h;
      diff_v  = neg_v ? span_v - twice_v : twice_v - span_v;
      dist_prod = req_chan.range_value * scale_ff
                + (rip_pkg::RANGE_W+rip_pkg::SCALE_W)'(128);
   end

   rip_phase_table u_table_h (
      .clock   (clock),
      .reset   (reset),
      .start   (start_h),
      .dim     (width_ff),
      .fov     (fov_h_ff),
      .rd_en   (adv),
      .rd_addr (diff_h),
      .rd_data (q_h),
      .busy    (busy_h)
   );

   rip_phase_table u_table_v (
      .clock   (clock),
      .reset   (reset),
      .start   (start_v),
      .dim     (height_ff),
      .fov     (fov_v_ff),
      .rd_en   (adv),
      .rd_addr (diff_v),
      .rd_data (q_v),
      .busy    (busy_v)
   );

   logic                          a_valid_ff;
   logic [rip_pkg::DIST_W-1:0]    a_dist_ff;
   logic [rip_pkg::STRENGTH_W-1:0] a_int_ff;
   logic                          a_neg_h_ff, a_neg_v_ff, a_zero_h_ff, a_zero_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= accept && (req_chan.range_value != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dist_ff   <= dist_prod[rip_pkg::DIST_W+7:8];
         a_int_ff    <= req_chan.strength_valid ? req_chan.strength_value : '0;
         a_neg_h_ff  <= neg_h;
         a_neg_v_ff  <= neg_v;
         a_zero_h_ff <= width_ff <= rip_pkg::DIM_W'(1);
         a_zero_v_ff <= height_ff <= rip_pkg::DIM_W'(1);
      end
   end

   // ---------------- stage P: signed phases ----------------
   logic [rip_pkg::PHASE_W-1:0] ph_h_ff, ph_v_ff;
   rip_pkg::side_type           side_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0].valid <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_h_ff <= a_zero_h_ff ? '0 : (a_neg_h_ff ? '0 - q_h : q_h);
         ph_v_ff <= a_zero_v_ff ? '0 : (a_neg_v_ff ? '0 - q_v : q_v);
         side_ff[0].distance  <= a_dist_ff;
         side_ff[0].intensity <= a_int_ff;
         side_ff[0].quad_h    <= a_zero_h_ff ? 2'd0 : (a_neg_h_ff ? 2'(('0 - q_h) >> 30)
                                                                  : q_h[31:30]);
         side_ff[0].quad_v    <= a_zero_v_ff ? 2'd0 : (a_neg_v_ff ? 2'(('0 - q_v) >> 30)
                                                                  : q_v[31:30]);
      end
   end

   // ---------------- CORDIC cell rows ----------------
   logic signed [rip_pkg::CORDIC_W-1:0] hx [NS+1];
   logic signed [rip_pkg::CORDIC_W-1:0] hy [NS+1];
   logic signed [rip_pkg::ANGLE_W-1:0]  hz [NS+1];
   logic signed [rip_pkg::CORDIC_W-1:0] vx [NS+1];
   logic signed [rip_pkg::CORDIC_W-1:0] vy [NS+1];
   logic signed [rip_pkg::ANGLE_W-1:0]  vz [NS+1];

   assign hx[0] = rip_pkg::CORDIC_ONE;
   assign hy[0] = '0;
   assign hz[0] = {3'b000, ph_h_ff[29:0]};
   assign vx[0] = rip_pkg::CORDIC_ONE;
   assign vy[0] = '0;
   assign vz[0] = {3'b000, ph_v_ff[29:0]};

   for (genvar i = 0; i < NS; i++) begin : g_cell
      rip_cordic_cell #(.STEP(i)) u_cell_h (
         .clock (clock), .en (adv),
         .x_i (hx[i]), .y_i (hy[i]), .z_i (hz[i]),
         .x_o (hx[i+1]), .y_o (hy[i+1]), .z_o (hz[i+1])
      );
      rip_cordic_cell #(.STEP(i)) u_cell_v (
         .clock (clock), .en (adv),
         .x_i (vx[i]), .y_i (vy[i]), .z_i (vz[i]),
         .x_o (vx[i+1]), .y_o (vy[i+1]), .z_o (vz[i+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i+1].valid <= 1'b0;
         end else if (adv) begin
            side_ff[i+1].valid <= side_ff[i].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[i+1].distance  <= side_ff[i].distance;
            side_ff[i+1].intensity <= side_ff[i].intensity;
            side_ff[i+1].quad_h    <= side_ff[i].quad_h;
            side_ff[i+1].quad_v    <= side_ff[i].quad_v;
         end
      end
   end

   // ---------------- stage Q: quadrant map ----------------
   logic signed [rip_pkg::CORDIC_W-1:0] cy_in, sy_in, cp_in, sp_in;
   logic signed [rip_pkg::CORDIC_W-1:0] cy_ff, sy_ff, cp_ff, sp_ff;
   logic                                q_valid_ff;
   logic [rip_pkg::DIST_W-1:0]          q_dist_ff;
   logic [rip_pkg::STRENGTH_W-1:0]      q_int_ff;

   always_comb begin
      case (side_ff[NS].quad_h)
         2'd0:    begin cy_in = hx[NS];  sy_in = hy[NS];  end
         2'd1:    begin cy_in = -hy[NS]; sy_in = hx[NS];  end
         2'd2:    begin cy_in = -hx[NS]; sy_in = -hy[NS]; end
         default: begin cy_in = hy[NS];  sy_in = -hx[NS]; end
      endcase
      case (side_ff[NS].quad_v)
         2'd0:    begin cp_in = vx[NS];  sp_in = vy[NS];  end
         2'd1:    begin cp_in = -vy[NS]; sp_in = vx[NS];  end
         2'd2:    begin cp_in = -vx[NS]; sp_in = -vy[NS]; end
         default: begin cp_in = vy[NS];  sp_in = -vx[NS]; end
      endcase
   end

   // ---------------- multiply stages ----------------
   logic signed [rip_pkg::DIST_W+rip_pkg::CORDIC_W:0] m1_hp, m1_zp;
   logic signed [PW-1:0]                              horiz_ff, zp_ff;
   logic signed [rip_pkg::CORDIC_W-1:0]               m1_cy_ff, m1_sy_ff;
   logic                                              m1_valid_ff;
   logic [rip_pkg::STRENGTH_W-1:0]                    m1_int_ff;

   logic signed [PW+rip_pkg::CORDIC_W-1:0]            m2_xp, m2_yp;
   logic signed [QW-1:0]                              x_raw_ff, y_raw_ff, z_raw_ff;
   logic                                              m2_valid_ff;
   logic [rip_pkg::STRENGTH_W-1:0]                    m2_int_ff;

   localparam logic signed [rip_pkg::DIST_W+rip_pkg::CORDIC_W:0] HALF1 =
      (rip_pkg::DIST_W+rip_pkg::CORDIC_W+1)'(1) <<< 29;
   localparam logic signed [PW+rip_pkg::CORDIC_W-1:0] HALF2 =
      (PW+rip_pkg::CORDIC_W)'(1) <<< 29;

   always_comb begin
      m1_hp = $signed({1'b0, q_dist_ff}) * cp_ff + HALF1;
      m1_zp = $signed({1'b0, q_dist_ff}) * sp_ff + HALF1;
      m2_xp = horiz_ff * m1_cy_ff + HALF2;
      m2_yp = horiz_ff * m1_sy_ff + HALF2;
   end

   function automatic logic signed [rip_pkg::POINT_W-1:0] sat33(
      input logic signed [QW-1:0] v
   );
      logic signed [QW-1:0] hi, lo;
      hi = QW'(64'sd4294967295);
      lo = -(QW'(64'sd4294967296));
      if (v > hi) begin
         return rip_pkg::POINT_W'(hi);
      end else if (v < lo) begin
         return rip_pkg::POINT_W'(lo);
      end
      return v[rip_pkg::POINT_W-1:0];
   endfunction

   logic signed [rip_pkg::POINT_W-1:0] x_out_ff, y_out_ff, z_out_ff;
   logic [rip_pkg::STRENGTH_W-1:0]     int_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         q_valid_ff   <= side_ff[NS].valid;
         m1_valid_ff  <= q_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cy_ff     <= cy_in;
         sy_ff     <= sy_in;
         cp_ff     <= cp_in;
         sp_ff     <= sp_in;
         q_dist_ff <= side_ff[NS].distance;
         q_int_ff  <= side_ff[NS].intensity;

         horiz_ff  <= m1_hp[PW+29:30];
         zp_ff     <= m1_zp[PW+29:30];
         m1_cy_ff  <= cy_ff;
         m1_sy_ff  <= sy_ff;
         m1_int_ff <= q_int_ff;

         x_raw_ff  <= m2_xp[QW+29:30];
         y_raw_ff  <= m2_yp[QW+29:30];
         z_raw_ff  <= -(QW'(zp_ff));
         m2_int_ff <= m1_int_ff;

         // hold the result until taken
         x_out_ff   <= sat33(x_raw_ff);
         y_out_ff   <= sat33(y_raw_ff);
         z_out_ff   <= sat33(z_raw_ff);
         int_out_ff <= m2_int_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.point_x   = x_out_ff;
   assign rsp_chan.point_y   = y_out_ff;
   assign rsp_chan.point_z   = z_out_ff;
   assign rsp_chan.intensity = int_out_ff;

endmodule

`default_nettype wire

/* src/rip_phase_table.sv */
// ----------------------------------------------------------------------------
// rip_phase_table: angle phase per index distance for one image axis
// Divides fov*2^32 by 2*(dim-1)*turn once, bit-serially, then sweeps the
// table accumulating quotient and remainder; read port has registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_phase_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rip_pkg::DIM_W-1:0]     dim,
   input  wire logic [rip_pkg::FOV_W-1:0]     fov,
   input  wire logic                          rd_en,
   input  wire logic [rip_pkg::DIFF_W-1:0]    rd_addr,
   output      logic [rip_pkg::PHASE_W-1:0]   rd_data,
   output      logic                          busy
);

   localparam int CNT_W = $clog2(rip_pkg::DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rip_pkg::DIVIDEND_W - 1);

   rip_pkg::table_state_type           state_ff, state_in;
   logic [rip_pkg::DEN_W-1:0]          den_ff, den_in;
   logic [rip_pkg::DIVIDEND_W-1:0]     dvd_ff, dvd_in;
   logic [rip_pkg::DEN_W-1:0]          rem_ff, rem_in;
   logic [rip_pkg::PHASE_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [rip_pkg::DIFF_W-1:0]         addr_ff, addr_in;
   logic [rip_pkg::PHASE_W-1:0]        acc_q_ff, acc_q_in;
   logic [rip_pkg::DEN_W-1:0]          acc_r_ff, acc_r_in;

   logic [rip_pkg::DIM_W-1:0]          span;
   logic [rip_pkg::DEN_W:0]            trial;
   logic                               trial_ge;
   logic [rip_pkg::DEN_W:0]            sum_r;
   logic                               wrap;

   logic [rip_pkg::PHASE_W-1:0]        mem [rip_pkg::TABLE_DEPTH];
   logic [rip_pkg::PHASE_W-1:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rip_pkg::PT_SETUP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff   <= den_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      addr_ff  <= addr_in;
      acc_q_ff <= acc_q_in;
      acc_r_ff <= acc_r_in;
   end

   always_comb begin
      span     = dim - rip_pkg::DIM_W'(1);
      trial    = {rem_ff, dvd_ff[rip_pkg::DIVIDEND_W-1]};
      trial_ge = trial >= {1'b0, den_ff};
      sum_r    = {1'b0, acc_r_ff} + {1'b0, rem_ff};
      wrap     = sum_r >= {1'b0, den_ff};

      state_in = state_ff;
      den_in   = den_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      acc_q_in = acc_q_ff;
      acc_r_in = acc_r_ff;

      unique case (state_ff)
         rip_pkg::PT_SETUP: begin
            den_in   = rip_pkg::DEN_W'(span * rip_pkg::DEN_W'(rip_pkg::DEN_STEP));
            dvd_in   = {fov, rip_pkg::PHASE_W'(0)};
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = rip_pkg::PT_DIVIDE;
         end
         rip_pkg::PT_DIVIDE: begin
            // one quotient bit a cycle
            rem_in = trial_ge ? rip_pkg::DEN_W'(trial - {1'b0, den_ff})
                              : trial[rip_pkg::DEN_W-1:0];
            quo_in = {quo_ff[rip_pkg::PHASE_W-2:0], trial_ge};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               addr_in  = '0;
               acc_q_in = '0;
               acc_r_in = den_ff >> 1;
               state_in = rip_pkg::PT_SWEEP;
            end
         end
         rip_pkg::PT_SWEEP: begin
            acc_r_in = wrap ? rip_pkg::DEN_W'(sum_r - {1'b0, den_ff})
                            : sum_r[rip_pkg::DEN_W-1:0];
            acc_q_in = acc_q_ff + quo_ff + rip_pkg::PHASE_W'(wrap);
            addr_in  = addr_ff + rip_pkg::DIFF_W'(1);
            if (addr_ff == rip_pkg::DIFF_W'(rip_pkg::DIFF_MAX)) begin
               state_in = rip_pkg::PT_IDLE;
            end
         end
         rip_pkg::PT_IDLE: begin
         end
         default: begin
            state_in = rip_pkg::PT_SETUP;
         end
      endcase

      if (start) begin
         state_in = rip_pkg::PT_SETUP;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rip_pkg::PT_SWEEP) begin
         mem[addr_ff] <= acc_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = state_ff != rip_pkg::PT_IDLE;

endmodule

`default_nettype wire

/* src/rip_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rip_cordic_cell: one rotation step of the sine/cosine cell row
// Rotates toward zero residual angle and hands x, y, z to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic signed [rip_pkg::CORDIC_W-1:0]   x_i,
   input  wire logic signed [rip_pkg::CORDIC_W-1:0]   y_i,
   input  wire logic signed [rip_pkg::ANGLE_W-1:0]    z_i,
   output      logic signed [rip_pkg::CORDIC_W-1:0]   x_o,
   output      logic signed [rip_pkg::CORDIC_W-1:0]   y_o,
   output      logic signed [rip_pkg::ANGLE_W-1:0]    z_o
);

   logic signed [rip_pkg::CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, x_sh, y_sh;
   logic signed [rip_pkg::ANGLE_W-1:0]  z_ff, z_in;

   always_comb begin
      x_sh = x_i >>> STEP;
      y_sh = y_i >>> STEP;
      if (!z_i[rip_pkg::ANGLE_W-1]) begin
         x_in = x_i - y_sh;
         y_in = y_i + x_sh;
         z_in = z_i - rip_pkg::ATAN_TURNS[STEP];
      end else begin
         x_in = x_i + y_sh;
         y_in = y_i - x_sh;
         z_in = z_i + rip_pkg::ATAN_TURNS[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

`default_nettype wire

/* verif/range_image_point_projector_unit_test.sv */
// ----------------------------------------------------------------------------
// range_image_point_projector_unit_test: self-checking point projector bench
// Drives pixel requests through several register settings, including single-
// pixel images, wrapped fields of view, out-of-image indexes and both scale
// extremes. A scoreboard predicts each point and checks every response in
// order. Both channels stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module range_image_point_projector_unit_test;

   localparam logic [rip_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [rip_pkg::COL_W-1:0]      column;
      logic [rip_pkg::COL_W-1:0]      row;
      logic [rip_pkg::RANGE_W-1:0]    range_value;
      logic [rip_pkg::STRENGTH_W-1:0] strength_value;
      logic                           strength_valid;
   } pixel_type;

   typedef struct {
      logic signed [rip_pkg::POINT_W-1:0] point_x;
      logic signed [rip_pkg::POINT_W-1:0] point_y;
      logic signed [rip_pkg::POINT_W-1:0] point_z;
      logic [rip_pkg::STRENGTH_W-1:0]     intensity;
   } point_type;

   class point_scoreboard;
      longint unsigned width_cfg, height_cfg, fov_h_cfg, fov_v_cfg, scale_cfg;
      point_type       pending_points[$];
      int              mismatches;
      int              checked;
      longint          atan_step[30];

      function new();
         atan_step = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
            'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
            'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
            'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
            'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
            'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
         width_cfg  = 256;
         height_cfg = 256;
         fov_h_cfg  = 23040;
         fov_v_cfg  = 5120;
         scale_cfg  = 16777;
      endfunction

      function void write_register(logic [rip_pkg::CSR_INDEX_W-1:0] idx,
                                   longint unsigned value);
         case (idx)
            rip_pkg::CSR_IMAGE_WIDTH:    width_cfg  = value & 'h7FF;
            rip_pkg::CSR_IMAGE_HEIGHT:   height_cfg = value & 'h7FF;
            rip_pkg::CSR_FOV_HORIZONTAL: fov_h_cfg  = value & 'h1FFFF;
            rip_pkg::CSR_FOV_VERTICAL:   fov_v_cfg  = value & 'h1FFFF;
            rip_pkg::CSR_RANGE_SCALE:    scale_cfg  = value & 'hFFFFFF;
            default: ;
         endcase
      endfunction

      function longint unsigned angle_phase(longint unsigned index, longint unsigned dim,
                                            longint unsigned fov);
         longint unsigned span, twice, diff, den, mag;
         logic            below;
         if (dim <= 1) return 0;
         span  = dim - 1;
         twice = index * 2;
         below = twice < span;
         diff  = below ? span - twice : twice - span;
         den   = 2 * span * rip_pkg::FOV_TURN;
         mag   = (((fov * diff) << 32) + den / 2) / den;
         mag   = mag & 64'hFFFF_FFFF;
         return below ? ((64'h1_0000_0000 - mag) & 64'hFFFF_FFFF) : mag;
      endfunction

      function void rotate(longint unsigned phase, output longint sin_v, output longint cos_v);
         longint xr, yr, zr, nx;
         xr = 652032874;
         yr = 0;
         zr = phase & 'h3FFF_FFFF;
         for (int i = 0; i < 30; i++) begin
            if (zr >= 0) begin
               nx = xr - (yr >>> i);
               yr = yr + (xr >>> i);
               zr = zr - atan_step[i];
            end else begin
               nx = xr + (yr >>> i);
               yr = yr - (xr >>> i);
               zr = zr + atan_step[i];
            end
            xr = nx;
         end
         case (phase[31:30])
            2'd0: begin cos_v = xr;  sin_v = yr;  end
            2'd1: begin cos_v = -yr; sin_v = xr;  end
            2'd2: begin cos_v = -xr; sin_v = -yr; end
            default: begin cos_v = yr; sin_v = -xr; end
         endcase
      endfunction

      function longint scale_q30(longint a, longint b);
         return (a * b + (longint'(1) << 29)) >>> 30;
      endfunction

      function logic signed [rip_pkg::POINT_W-1:0] clamp(longint v);
         if (v > 64'sd4294967295) v = 64'sd4294967295;
         if (v < -64'sd4294967296) v = -64'sd4294967296;
         return v[rip_pkg::POINT_W-1:0];
      endfunction

      // compute the point of an accepted request; zero range yields none
      function void note_request(pixel_type px);
         longint    distance, sy, cy, sp, cp, horiz;
         point_type pt;
         if (px.range_value == 0) return;
         distance = longint'((longint'(px.range_value) * scale_cfg + 128) >> 8);
         rotate(angle_phase(px.column, width_cfg, fov_h_cfg), sy, cy);
         rotate(angle_phase(px.row, height_cfg, fov_v_cfg), sp, cp);
         horiz        = scale_q30(distance, cp);
         pt.point_x   = clamp(scale_q30(horiz, cy));
         pt.point_y   = clamp(scale_q30(horiz, sy));
         pt.point_z   = clamp(-scale_q30(distance, sp));
         pt.intensity = px.strength_valid ? px.strength_value : '0;
         pending_points = {pending_points, pt};
      endfunction

      function void check_point(point_type got);
         point_type want;
         checked++;
         if (pending_points.size() == 0) begin
            $error("response with no request pending");
            mismatches++;
            return;
         end
         want = pending_points.pop_front();
         if (got.point_x !== want.point_x) begin
            $error("point_x expected %0d got %0d", want.point_x, got.point_x);
            mismatches++;
         end
         if (got.point_y !== want.point_y) begin
            $error("point_y expected %0d got %0d", want.point_y, got.point_y);
            mismatches++;
         end
         if (got.point_z !== want.point_z) begin
            $error("point_z expected %0d got %0d", want.point_z, got.point_z);
            mismatches++;
         end
         if (got.intensity !== want.intensity) begin
            $error("intensity expected %0d got %0d", want.intensity, got.intensity);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [rip_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rip_pkg::CSR_DATA_W-1:0]  csr_wdata;

   rip_req_if req_chan ();
   rip_rsp_if rsp_chan ();

   range_image_point_projector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   point_scoreboard points = new();
   logic quiet;
   int   sent_count;
   int   stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // observe both channels
   always @(posedge clock) begin
      pixel_type px;
      point_type pt;
      if (!reset && req_chan.valid && req_chan.ready) begin
         px.column         = req_chan.column;
         px.row            = req_chan.row;
         px.range_value    = req_chan.range_value;
         px.strength_value = req_chan.strength_value;
         px.strength_valid = req_chan.strength_valid;
         points.note_request(px);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         pt.point_x   = rsp_chan.point_x;
         pt.point_y   = rsp_chan.point_y;
         pt.point_z   = rsp_chan.point_z;
         pt.intensity = rsp_chan.intensity;
         points.check_point(pt);
      end
   end

   // response backpressure in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= stall_left == 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic write_csr(logic [rip_pkg::CSR_INDEX_W-1:0] idx, longint unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[rip_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      points.write_register(idx, value);
   endtask

   task automatic configure(int w, int h, int fh, int fv, int sc);
      write_csr(rip_pkg::CSR_IMAGE_WIDTH, longint'(w));
      write_csr(rip_pkg::CSR_IMAGE_HEIGHT, longint'(h));
      write_csr(rip_pkg::CSR_FOV_HORIZONTAL, longint'(fh));
      write_csr(rip_pkg::CSR_FOV_VERTICAL, longint'(fv));
      write_csr(rip_pkg::CSR_RANGE_SCALE, longint'(sc));
   endtask

   // hold the request until it is taken, maybe after an idle burst
   task automatic send_pixel(int column, int row, int range_value, int strength, bit present);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.column         <= rip_pkg::COL_W'(column);
      req_chan.row            <= rip_pkg::COL_W'(row);
      req_chan.range_value    <= rip_pkg::RANGE_W'(range_value);
      req_chan.strength_value <= rip_pkg::STRENGTH_W'(strength);
      req_chan.strength_valid <= present;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (points.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_pixels(int count);
      int col, row, rng, wmax, hmax;
      wmax = int'(points.width_cfg > 1024 ? 1023 :
                  (points.width_cfg == 0 ? 0 : points.width_cfg - 1));
      hmax = int'(points.height_cfg > 1024 ? 1023 :
                  (points.height_cfg == 0 ? 0 : points.height_cfg - 1));
      repeat (count) begin
         col = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, wmax);
         row = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, hmax);
         case ($urandom_range(0, 9))
            0: rng = 0;
            1: rng = 65535;
            default: rng = $urandom_range(1, 65535);
         endcase
         send_pixel(col, row, rng, $urandom_range(0, 255), $urandom_range(0, 1));
      end
      drain();
   endtask

   initial begin
      reset                   = 1'b1;
      quiet                   = 1'b0;
      sent_count              = 0;
      csr_we                  = 1'b0;
      csr_index               = '0;
      csr_wdata               = '0;
      req_chan.valid          = 1'b0;
      req_chan.column         = '0;
      req_chan.row            = '0;
      req_chan.range_value    = '0;
      req_chan.strength_value = '0;
      req_chan.strength_valid = 1'b0;
      rsp_chan.ready          = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners at reset settings
      send_pixel(0, 0, 1, 0, 1'b1);
      send_pixel(255, 255, 65535, 255, 1'b1);
      send_pixel(1023, 1023, 65535, 255, 1'b0);
      send_pixel(128, 128, 0, 77, 1'b1);
      send_pixel(127, 128, 1000, 170, 1'b1);
      send_pixel(0, 255, 40000, 85, 1'b0);
      send_pixel(1023, 0, 12345, 1, 1'b1);
      send_pixel(300, 700, 2, 254, 1'b1);
      drain();

      // single-pixel image, full-turn field of view, largest scale
      configure(1, 1, 92160, 92160, 24'hFFFFFF);
      send_pixel(0, 0, 65535, 255, 1'b1);
      send_pixel(1023, 1023, 65535, 0, 1'b1);
      send_pixel(5, 9, 1, 3, 1'b0);
      drain();

      // zero-sized and oversized dimensions, field past a turn, zero scale
      configure(0, 2047, 131071, 0, 0);
      send_pixel(1023, 1023, 65535, 200, 1'b1);
      send_pixel(0, 0, 9, 11, 1'b1);
      drain();
      write_csr(CSR_SPARE_INDEX, 24'h000003);
      write_csr(rip_pkg::CSR_RANGE_SCALE, 24'hFFFFFF);
      send_pixel(1023, 0, 65535, 5, 1'b1);
      send_pixel(0, 1023, 30000, 6, 1'b0);
      random_pixels(40);

      configure(2, 3, 131071, 131071, 24'hFFFFFF);
      random_pixels(150);
      configure(1024, 1024, 92160, 92160, 16777);
      random_pixels(200);
      configure(2047, 2, 46080, 46080, 24'h800000);

      random_pixels(150);
      repeat (4) begin
         configure($urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(0, 131071), $urandom_range(0, 131071),
                   $urandom_range(0, 24'hFFFFFF));
         random_pixels(150);
      end

      quiet = 1'b1;
      configure(64, 32, 23040, 5120, 16777);
      random_pixels(150);

      $display("Sent %0d pixel requests across reset, corner and random register settings;",
               sent_count);
      $display("%0d points compared against the predicted projection.", points.checked);
      if (points.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
